// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define VLIA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assert an implication on the rising clock edge, disabled while reset is low.
`define VLIA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `VLIA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: hdl/vlia_pkg.sv
// ----------------------------------------------------------------------------
// vlia_pkg
// Opcodes, widths and shared types of the vector lane integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package vlia_pkg;

    localparam int unsigned OP_W    = 5;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned SHAMT_W = 5;
    localparam int unsigned I24_W   = 24;

    typedef enum logic [OP_W-1:0] {
        OP_CNDMASK_B32 = 5'd0,
        OP_MUL_I32_I24 = 5'd1,
        OP_MULLO_I32   = 5'd2,
        OP_MUL_I64_I32 = 5'd3,
        OP_MIN_I32     = 5'd4,
        OP_MAX_I32     = 5'd5,
        OP_MIN_U32     = 5'd6,
        OP_MAX_U32     = 5'd7,
        OP_LSHRREV_B32 = 5'd8,
        OP_ASHRREV_I32 = 5'd9,
        OP_LSHL_B32    = 5'd10,
        OP_LSHLREV_B32 = 5'd11,
        OP_AND_B32     = 5'd12,
        OP_OR_B32      = 5'd13,
        OP_XOR_B32     = 5'd14,
        OP_ADD_I32     = 5'd15,
        OP_ADD_U32     = 5'd16,
        OP_ADDCO_U32   = 5'd17,
        OP_SUB_I32     = 5'd18,
        OP_SUB_U32     = 5'd19,
        OP_SUBREV_I32  = 5'd20,
        OP_SUBREV_U32  = 5'd21,
        OP_ADD_I64     = 5'd22,
        OP_ASHR_I64    = 5'd23,
        OP_LSHL_B64    = 5'd24
    } t_op;

    typedef enum logic [1:0] {
        RS_ALU      = 2'd0,
        RS_MUL_LO   = 2'd1,
        RS_MUL_FULL = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              carry_out;
        logic              carry_valid;
    } t_alu_out;

    function automatic logic [WORD_W-1:0] sext24(input logic [WORD_W-1:0] x);
        return {{(WORD_W-I24_W){x[I24_W-1]}}, x[I24_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// File: hdl/vector_lane_integer_alu.sv
// ----------------------------------------------------------------------------
// vector_lane_integer_alu
// Three-stage integer ALU for one vector lane: operand capture and multiply
// operand preparation, execute with partial products, and product summation
// with result selection into the output register.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  i_op, i_src_a, i_src_b, i_vcc_in
//   result    out        o_valid / i_ready  o_result, o_carry_out, o_carry_valid
//
// One request enters per cycle while o_ready is high; each result passes through
// the stage 1, stage 2 and output registers and leaves when i_ready is high.
// The pipeline has three register stages; the multiplier is split into
// 16-bit partial products in the execute stage and their sum in the last stage.
// Reset (synchronous, active low) clears the stage valid bits only.
// A stall on i_ready holds the output register; earlier stages keep filling
// empty slots, and o_ready drops only when all three stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_lane_integer_alu
    import vlia_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [DATA_W-1:0] i_src_a,
    input  wire logic [DATA_W-1:0] i_src_b,
    input  wire logic              i_vcc_in,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_result,
    output logic                   o_carry_out,
    output logic                   o_carry_valid
);

    logic w_en1;
    logic w_en2;
    logic w_en3;

    // stage 1: captured request
    logic              r_v1;
    t_op               r_s1_op;
    logic [DATA_W-1:0] r_s1_a;
    logic [DATA_W-1:0] r_s1_b;
    logic              r_s1_vcc;
    logic [WORD_W-1:0] r_s1_mx;
    logic [WORD_W-1:0] r_s1_my;
    t_res_sel          r_s1_sel;

    t_op               n_s1_op;
    logic [WORD_W-1:0] n_s1_mx;
    logic [WORD_W-1:0] n_s1_my;
    t_res_sel          n_s1_sel;

    // stage 2: executed
    logic              r_v2;
    logic [DATA_W-1:0] w_prod;
    t_alu_out          r_s2_alu;
    t_res_sel          r_s2_sel;

    t_alu_out          n_s2_alu;

    // stage 3: output register
    logic              r_v3;
    t_alu_out          r_s3_out;
    t_alu_out          n_s3_out;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        n_s1_op = t_op'(i_op);
        n_s1_mx = i_src_a[WORD_W-1:0];
        n_s1_my = i_src_b[WORD_W-1:0];
        if (n_s1_op == OP_MUL_I32_I24) begin
            n_s1_mx = sext24(i_src_a[WORD_W-1:0]);
            n_s1_my = sext24(i_src_b[WORD_W-1:0]);
        end
        if (n_s1_op inside {OP_MUL_I32_I24, OP_MULLO_I32}) begin
            n_s1_sel = RS_MUL_LO;
        end else if (n_s1_op == OP_MUL_I64_I32) begin
            n_s1_sel = RS_MUL_FULL;
        end else begin
            n_s1_sel = RS_ALU;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_op  <= n_s1_op;
            r_s1_a   <= i_src_a;
            r_s1_b   <= i_src_b;
            r_s1_vcc <= i_vcc_in;
            r_s1_mx  <= n_s1_mx;
            r_s1_my  <= n_s1_my;
            r_s1_sel <= n_s1_sel;
        end
    end

    vlia_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en2),
        .i_x    (r_s1_mx),
        .i_y    (r_s1_my),
        .o_prod (w_prod)
    );

    vlia_alu u_alu (
        .i_op     (r_s1_op),
        .i_src_a  (r_s1_a),
        .i_src_b  (r_s1_b),
        .i_vcc_in (r_s1_vcc),
        .o_alu    (n_s2_alu)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_alu <= n_s2_alu;
            r_s2_sel <= r_s1_sel;
        end
    end

    always_comb begin
        n_s3_out = r_s2_alu;
        case (r_s2_sel)
            RS_MUL_LO: begin
                n_s3_out = '0;
                n_s3_out.result = DATA_W'(w_prod[WORD_W-1:0]);
            end
            RS_MUL_FULL: begin
                n_s3_out = '0;
                n_s3_out.result = w_prod;
            end
            default: begin
                n_s3_out = r_s2_alu;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_out <= n_s3_out;
        end
    end

    assign o_valid       = r_v3;
    assign o_result      = r_s3_out.result;
    assign o_carry_out   = r_s3_out.carry_out;
    assign o_carry_valid = r_s3_out.carry_valid;

endmodule

`default_nettype wire

// File: hdl/vlia_mul.sv
// ----------------------------------------------------------------------------
// vlia_mul
// Signed 32 x 32 multiplier over two stages: 16-bit partial products are
// registered, then summed into the full 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module vlia_mul
    import vlia_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [WORD_W-1:0] i_x,
    input  wire logic [WORD_W-1:0] i_y,
    output logic      [DATA_W-1:0] o_prod
);

    logic signed [HALF_W-1:0] w_xh;
    logic signed [HALF_W-1:0] w_yh;
    logic signed [HALF_W:0]   w_xl;
    logic signed [HALF_W:0]   w_yl;

    logic signed [WORD_W-1:0] n_hh;
    logic signed [WORD_W:0]   n_hl;
    logic signed [WORD_W:0]   n_lh;
    logic        [WORD_W-1:0] n_ll;

    logic signed [WORD_W-1:0] r_hh;
    logic signed [WORD_W:0]   r_hl;
    logic signed [WORD_W:0]   r_lh;
    logic        [WORD_W-1:0] r_ll;

    // signed upper halves, unsigned lower halves
    assign w_xh = signed'(i_x[WORD_W-1:HALF_W]);
    assign w_yh = signed'(i_y[WORD_W-1:HALF_W]);
    assign w_xl = signed'({1'b0, i_x[HALF_W-1:0]});
    assign w_yl = signed'({1'b0, i_y[HALF_W-1:0]});

    assign n_hh = WORD_W'(w_xh) * WORD_W'(w_yh);
    assign n_hl = (WORD_W+1)'(w_xh) * (WORD_W+1)'(w_yl);
    assign n_lh = (WORD_W+1)'(w_xl) * (WORD_W+1)'(w_yh);
    assign n_ll = {{(WORD_W-HALF_W){1'b0}}, i_x[HALF_W-1:0]}
                * {{(WORD_W-HALF_W){1'b0}}, i_y[HALF_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
        end
    end

    assign o_prod = {r_hh, {WORD_W{1'b0}}}
                  + {{(DATA_W-WORD_W-HALF_W-1){r_hl[WORD_W]}}, r_hl, {HALF_W{1'b0}}}
                  + {{(DATA_W-WORD_W-HALF_W-1){r_lh[WORD_W]}}, r_lh, {HALF_W{1'b0}}}
                  + {{(DATA_W-WORD_W){1'b0}}, r_ll};

endmodule

`default_nettype wire

// File: hdl/vlia_alu.sv
// ----------------------------------------------------------------------------
// vlia_alu
// Non-multiply operations: select, min/max, shifts, logic, add and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module vlia_alu
    import vlia_pkg::*;
(
    input  wire t_op               i_op,
    input  wire logic [DATA_W-1:0] i_src_a,
    input  wire logic [DATA_W-1:0] i_src_b,
    input  wire logic              i_vcc_in,
    output t_alu_out               o_alu
);

    logic [WORD_W-1:0]  w_a;
    logic [WORD_W-1:0]  w_b;
    logic [SHAMT_W-1:0] w_sh_a;
    logic [SHAMT_W-1:0] w_sh_b;
    logic [WORD_W-1:0]  w_shl;
    logic [WORD_W-1:0]  w_shlrev;
    logic               w_rev;
    logic [WORD_W-1:0]  w_sub_x;
    logic [WORD_W-1:0]  w_sub_y;
    logic [WORD_W-1:0]  w_diff;
    logic [WORD_W:0]    w_sum32;
    logic [DATA_W:0]    w_sum64;
    logic               w_s_a_gt_b;
    logic               w_s_b_gt_a;
    logic               w_u_a_gt_b;
    logic               w_u_b_gt_a;
    logic               w_s_brw;
    logic               w_u_brw;

    assign w_a    = i_src_a[WORD_W-1:0];
    assign w_b    = i_src_b[WORD_W-1:0];
    assign w_sh_a = w_a[SHAMT_W-1:0];
    assign w_sh_b = w_b[SHAMT_W-1:0];

    assign w_shl    = w_a << w_sh_b;
    assign w_shlrev = w_b << w_sh_a;

    assign w_s_a_gt_b = $signed(w_a) > $signed(w_b);
    assign w_s_b_gt_a = $signed(w_b) > $signed(w_a);
    assign w_u_a_gt_b = w_a > w_b;
    assign w_u_b_gt_a = w_b > w_a;

    // reversed subtract swaps the operands
    assign w_rev   = (i_op inside {OP_SUBREV_I32, OP_SUBREV_U32});
    assign w_sub_x = w_rev ? w_b : w_a;
    assign w_sub_y = w_rev ? w_a : w_b;
    assign w_diff  = w_sub_x - w_sub_y;
    assign w_s_brw = w_rev ? w_s_a_gt_b : w_s_b_gt_a;
    assign w_u_brw = w_rev ? w_u_a_gt_b : w_u_b_gt_a;

    assign w_sum32 = {1'b0, w_a} + {1'b0, w_b};
    assign w_sum64 = {1'b0, i_src_a} + {1'b0, i_src_b};

    always_comb begin
        o_alu = '0;
        case (i_op)
            OP_CNDMASK_B32: begin
                o_alu.result = DATA_W'(i_vcc_in ? w_b : w_a);
            end
            OP_MIN_I32: begin
                o_alu.result = DATA_W'(w_s_b_gt_a ? w_a : w_b);
            end
            OP_MAX_I32: begin
                o_alu.result = DATA_W'(w_s_a_gt_b ? w_a : w_b);
            end
            OP_MIN_U32: begin
                o_alu.result = DATA_W'(w_u_b_gt_a ? w_a : w_b);
            end
            OP_MAX_U32: begin
                o_alu.result = DATA_W'(w_u_a_gt_b ? w_a : w_b);
            end
            OP_LSHRREV_B32: begin
                o_alu.result = DATA_W'(w_b >> w_sh_a);
            end
            OP_ASHRREV_I32: begin
                o_alu.result = DATA_W'(unsigned'($signed(w_b) >>> w_sh_a));
            end
            OP_LSHL_B32: begin
                o_alu.result = DATA_W'(w_shl);
            end
            OP_LSHLREV_B32: begin
                o_alu.result = DATA_W'(w_shlrev);
            end
            OP_AND_B32: begin
                o_alu.result = DATA_W'(w_a & w_b);
            end
            OP_OR_B32: begin
                o_alu.result = DATA_W'(w_a | w_b);
            end
            OP_XOR_B32: begin
                o_alu.result = DATA_W'(w_a ^ w_b);
            end
            OP_ADD_I32, OP_ADD_U32, OP_ADDCO_U32: begin
                o_alu.result      = DATA_W'(w_sum32[WORD_W-1:0]);
                o_alu.carry_out   = w_sum32[WORD_W];
                o_alu.carry_valid = 1'b1;
            end
            OP_SUB_I32, OP_SUBREV_I32: begin
                o_alu.result      = DATA_W'(w_diff);
                o_alu.carry_out   = w_s_brw;
                o_alu.carry_valid = 1'b1;
            end
            OP_SUB_U32, OP_SUBREV_U32: begin
                o_alu.result      = DATA_W'(w_diff);
                o_alu.carry_out   = w_u_brw;
                o_alu.carry_valid = 1'b1;
            end
            OP_ADD_I64: begin
                o_alu.result      = w_sum64[DATA_W-1:0];
                o_alu.carry_out   = w_sum64[DATA_W];
                o_alu.carry_valid = 1'b1;
            end
            OP_ASHR_I64: begin
                o_alu.result = unsigned'($signed(i_src_a) >>> w_sh_b);
            end
            OP_LSHL_B64: begin
                o_alu.result = i_src_a << w_sh_b;
            end
            default: begin
                o_alu = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/vlia_checker.sv
// ----------------------------------------------------------------------------
// vlia_checker
// Port-level checks of the vector lane integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vlia_checker
    import vlia_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [DATA_W-1:0] o_result,
    input wire logic              o_carry_out,
    input wire logic              o_carry_valid
);

    logic w_out_stall;

    assign w_out_stall = o_valid && !i_ready;

    `VLIA_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, w_out_stall, ##1 o_valid, "result dropped while stalled")
    `VLIA_ASSERT_IMPL(a_out_stable, i_clk, i_rst_n, w_out_stall, ##1 ($stable(o_result) && $stable(o_carry_out) && $stable(o_carry_valid)), "result changed while stalled")
    `VLIA_ASSERT_IMPL(a_carry_qual, i_clk, i_rst_n, o_valid && !o_carry_valid, !o_carry_out, "carry out without carry valid")
    `VLIA_ASSERT_IMPL(a_full_only, i_clk, i_rst_n, !o_ready, o_valid, "request refused with empty output")

endmodule

bind vector_lane_integer_alu vlia_checker u_vlia_checker (.*);

`default_nettype wire

// File: tb/vector_lane_integer_alu_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_lane_integer_alu_tb
// Self-checking bench for the lane integer ALU. A table of directed requests
// covers every opcode, the operand extremes, shift-count masking, the signed
// borrow of the I32 subtracts and the unused opcodes; random requests follow.
// Each result is compared in order against a typed-in value or against a
// behavioural model of the ALU. Both handshakes idle at random, apart from
// one window where they run flat out.
// ----------------------------------------------------------------------------
module vector_lane_integer_alu_tb;
    import vlia_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 5'd25;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 5'd31;
    localparam int unsigned     IDLE_PCT     = 21;
    localparam int unsigned     RAND_REQS    = 1050;
    localparam int unsigned     DRAIN_CYCLES = 10;
    localparam logic [63:0]     ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              vcc;
        logic              known;
        logic [DATA_W-1:0] res;
        logic              cy;
        logic              cv;
    } t_alu_request;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [OP_W-1:0]   i_op          = '0;
    logic [DATA_W-1:0] i_src_a       = '0;
    logic [DATA_W-1:0] i_src_b       = '0;
    logic              i_vcc_in      = 1'b0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [DATA_W-1:0] o_result;
    logic              o_carry_out;
    logic              o_carry_valid;

    t_alu_request request_q[$];
    t_alu_out     pending_results[$];
    int unsigned  req_idx  = 0;
    int unsigned  cyc_cnt  = 0;
    int unsigned  fail_cnt = 0;
    wire          calm     = (cyc_cnt >= 600) && (cyc_cnt < 900);

    t_alu_request directed [29] = '{
        '{OP_CNDMASK_B32, ONES, 64'h0, 1'b0, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b0},
        '{OP_CNDMASK_B32, 64'h0, ONES, 1'b1, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b0},
        '{OP_MUL_I32_I24, 64'h0080_0000, 64'h0080_0000, 1'b0, 1'b1, 64'h0, 1'b0, 1'b0},
        '{OP_MUL_I32_I24, 64'hFFFF_FFFF_00FF_FFFF, 64'h007F_FFFF, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0},
        '{OP_MULLO_I32, ONES, ONES, 1'b0, 1'b1, 64'h1, 1'b0, 1'b0},
        '{OP_MUL_I64_I32, 64'h8000_0000, 64'h8000_0000, 1'b0, 1'b1,
          64'h4000_0000_0000_0000, 1'b0, 1'b0},
        '{OP_MIN_I32, 64'h8000_0000, 64'h7FFF_FFFF, 1'b0, 1'b1, 64'h8000_0000, 1'b0, 1'b0},
        '{OP_MAX_I32, 64'h8000_0000, 64'h7FFF_FFFF, 1'b0, 1'b1, 64'h7FFF_FFFF, 1'b0, 1'b0},
        '{OP_MIN_U32, 64'h8000_0000, 64'h7FFF_FFFF, 1'b0, 1'b1, 64'h7FFF_FFFF, 1'b0, 1'b0},
        '{OP_MAX_U32, 64'h0, ONES, 1'b0, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b0},
        '{OP_LSHRREV_B32, ONES, 64'h8000_0000, 1'b0, 1'b1, 64'h1, 1'b0, 1'b0},
        '{OP_ASHRREV_I32, 64'h3F, 64'h8000_0000, 1'b0, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b0},
        '{OP_LSHL_B32, 64'h1, 64'h20, 1'b0, 1'b1, 64'h1, 1'b0, 1'b0},
        '{OP_LSHLREV_B32, 64'h1F, 64'h3, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0},
        '{OP_AND_B32, 64'hF0F0_F0F0_1234_5678, 64'h0F0F_0F0F_FFFF_0000, 1'b0, 1'b0,
          64'h0, 1'b0, 1'b0},
        '{OP_OR_B32, 64'hF0F0_F0F0_1234_5678, 64'h0F0F_0F0F_FFFF_0000, 1'b1, 1'b0,
          64'h0, 1'b0, 1'b0},
        '{OP_XOR_B32, 64'hF0F0_F0F0_1234_5678, 64'h0F0F_0F0F_FFFF_0000, 1'b0, 1'b0,
          64'h0, 1'b0, 1'b0},
        '{OP_ADD_I32, 64'hFFFF_FFFF, 64'h1, 1'b0, 1'b1, 64'h0, 1'b1, 1'b1},
        '{OP_ADD_U32, 64'h7FFF_FFFF, 64'h1, 1'b0, 1'b1, 64'h8000_0000, 1'b0, 1'b1},
        '{OP_ADDCO_U32, 64'h8000_0000, 64'h8000_0000, 1'b0, 1'b1, 64'h0, 1'b1, 1'b1},
        '{OP_SUB_I32, 64'h7FFF_FFFF, 64'h8000_0000, 1'b0, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b1},
        '{OP_SUB_U32, 64'h0, 64'h1, 1'b0, 1'b1, 64'hFFFF_FFFF, 1'b1, 1'b1},
        '{OP_SUBREV_I32, 64'h1, 64'h8000_0000, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0},
        '{OP_SUBREV_U32, 64'h5, 64'h3, 1'b0, 1'b0, 64'h0, 1'b0, 1'b0},
        '{OP_ADD_I64, ONES, 64'h1, 1'b0, 1'b1, 64'h0, 1'b1, 1'b1},
        '{OP_ASHR_I64, 64'h8000_0000_0000_0000, 64'h3F, 1'b0, 1'b1,
          64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0},
        '{OP_LSHL_B64, ONES, 64'h3F, 1'b0, 1'b1, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0},
        '{OP_UNUSED_LO, ONES, ONES, 1'b1, 1'b1, 64'h0, 1'b0, 1'b0},
        '{OP_UNUSED_HI, ONES, ONES, 1'b1, 1'b1, 64'h0, 1'b0, 1'b0}
    };

    vector_lane_integer_alu u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_src_a       (i_src_a),
        .i_src_b       (i_src_b),
        .i_vcc_in      (i_vcc_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (o_result),
        .o_carry_out   (o_carry_out),
        .o_carry_valid (o_carry_valid)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_alu_out alu_predict(input logic [OP_W-1:0] op,
                                             input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b,
                                             input logic vcc);
        logic [WORD_W-1:0]        a32;
        logic [WORD_W-1:0]        b32;
        logic [WORD_W-1:0]        r32;
        logic signed [47:0]       p48;
        logic [DATA_W-1:0]        p64;
        logic signed [DATA_W-1:0] sp64;
        logic [WORD_W:0]          s33;
        logic [DATA_W:0]          s65;
        t_alu_out                 o;
        a32 = a[WORD_W-1:0];
        b32 = b[WORD_W-1:0];
        o   = '0;
        r32 = '0;
        case (op)
            OP_CNDMASK_B32: r32 = vcc ? b32 : a32;
            OP_MUL_I32_I24: begin
                p48 = $signed(a32[23:0]) * $signed(b32[23:0]);
                r32 = p48[WORD_W-1:0];
            end
            OP_MULLO_I32: begin
                p64 = {32'b0, a32} * {32'b0, b32};
                r32 = p64[WORD_W-1:0];
            end
            OP_MIN_I32:     r32 = ($signed(b32) > $signed(a32)) ? a32 : b32;
            OP_MAX_I32:     r32 = ($signed(a32) > $signed(b32)) ? a32 : b32;
            OP_MIN_U32:     r32 = (a32 < b32) ? a32 : b32;
            OP_MAX_U32:     r32 = (a32 > b32) ? a32 : b32;
            OP_LSHRREV_B32: r32 = b32 >> a32[SHAMT_W-1:0];
            OP_ASHRREV_I32: r32 = $signed(b32) >>> a32[SHAMT_W-1:0];
            OP_LSHL_B32:    r32 = a32 << b32[SHAMT_W-1:0];
            OP_LSHLREV_B32: r32 = b32 << a32[SHAMT_W-1:0];
            OP_AND_B32:     r32 = a32 & b32;
            OP_OR_B32:      r32 = a32 | b32;
            OP_XOR_B32:     r32 = a32 ^ b32;
            OP_ADD_I32, OP_ADD_U32, OP_ADDCO_U32: begin
                s33 = {1'b0, a32} + {1'b0, b32};
                r32 = s33[WORD_W-1:0];
                o.carry_out = s33[WORD_W];
            end
            OP_SUB_I32: begin
                r32 = a32 - b32;
                o.carry_out = $signed(b32) > $signed(a32);
            end
            OP_SUB_U32: begin
                r32 = a32 - b32;
                o.carry_out = b32 > a32;
            end
            OP_SUBREV_I32: begin
                r32 = b32 - a32;
                o.carry_out = $signed(a32) > $signed(b32);
            end
            OP_SUBREV_U32: begin
                r32 = b32 - a32;
                o.carry_out = a32 > b32;
            end
            default: ;
        endcase
        o.result = {32'b0, r32};
        case (op)
            OP_MUL_I64_I32: begin
                sp64 = $signed(a32) * $signed(b32);
                o.result = sp64;
            end
            OP_ADD_I64: begin
                s65 = {1'b0, a} + {1'b0, b};
                o.result    = s65[DATA_W-1:0];
                o.carry_out = s65[DATA_W];
            end
            OP_ASHR_I64: o.result = $signed(a) >>> b32[SHAMT_W-1:0];
            OP_LSHL_B64: o.result = a << b32[SHAMT_W-1:0];
            default: ;
        endcase
        o.carry_valid = (op >= OP_ADD_I32) && (op <= OP_ADD_I64);
        return o;
    endfunction

    function automatic t_alu_out expected_for(input t_alu_request r);
        t_alu_out o;
        if (r.known) begin
            o.result      = r.res;
            o.carry_out   = r.cy;
            o.carry_valid = r.cv;
        end else begin
            o = alu_predict(r.op, r.a, r.b, r.vcc);
        end
        return o;
    endfunction

    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ONES;
            2: v[WORD_W-1:0] = 32'h8000_0000;
            3: v[WORD_W-1:0] = 32'h7FFF_FFFF;
            4: v[WORD_W-1:0] = $urandom_range(0, 40);
            5: v[WORD_W-1:0] = 32'hFFFF_FFFF - $urandom_range(0, 40);
            6: v[63:60] = {4{$urandom_range(0, 1) == 1}};
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        t_alu_request r;
        foreach (directed[i]) request_q.push_back(directed[i]);
        repeat (RAND_REQS) begin
            r       = '0;
            r.op    = ($urandom_range(0, 9) == 0)
                      ? OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
                      : OP_W'($urandom_range(OP_CNDMASK_B32, OP_LSHL_B64));
            r.a     = rand_operand();
            r.b     = rand_operand();
            r.vcc   = 1'($urandom_range(0, 1));
            request_q.push_back(r);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin : drive_and_check
        int unsigned nxt;
        t_alu_out    want;
        if (i_rst_n) begin
            cyc_cnt <= cyc_cnt + 1;
            i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h carry %b valid %b", $time,
                             o_result, o_carry_out, o_carry_valid);
                    fail_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result !== want.result || o_carry_out !== want.carry_out ||
                        o_carry_valid !== want.carry_valid) begin
                        $display("%0t: expected %h carry %b valid %b, got %h %b %b", $time,
                                 want.result, want.carry_out, want.carry_valid,
                                 o_result, o_carry_out, o_carry_valid);
                        fail_cnt++;
                    end
                end
            end

            nxt = req_idx;
            if (i_valid && o_ready) begin
                pending_results.push_back(expected_for(request_q[req_idx]));
                nxt = req_idx + 1;
            end
            req_idx <= nxt;

            // hold the request until it is taken
            if (!i_valid || o_ready) begin
                if (nxt < request_q.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_valid  <= 1'b1;
                    i_op     <= request_q[nxt].op;
                    i_src_a  <= request_q[nxt].a;
                    i_src_b  <= request_q[nxt].b;
                    i_vcc_in <= request_q[nxt].vcc;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (req_idx < request_q.size() || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
